/* rtl/core/lsra_pkg.sv */
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared constants, codes and types of the linear-scan register assigner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsra_pkg;

  localparam int unsigned NUM_REGS    = 9;
  localparam int unsigned REG_IDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned REG_FIELD_W = 4;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned ID_W        = 12;
  localparam int unsigned OFF_W       = 16;
  localparam int unsigned SLOT_W      = OFF_W + 1;
  localparam int unsigned OUTCOME_W   = 2;

  localparam logic [OFF_W:0] MAX_OFFSET  = (OFF_W+1)'(32768);
  localparam logic [OFF_W:0] SLOT_BIAS   = (OFF_W+1)'(8);
  localparam int unsigned    SLOT_STEP   = 4;
  localparam logic [OFF_W:0] STEP_ROUND  = (OFF_W+1)'(SLOT_STEP + 3);
  localparam logic [OFF_W:0] ALIGN4_MASK = ~((OFF_W+1)'(3));
  localparam logic [OFF_W:0] FRAME_ROUND = (OFF_W+1)'(15);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_GRANT = 2'd0,
    OUT_EVICT = 2'd1,
    OUT_SKIP  = 2'd2
  } outcome_e;

  // register choice for one interval
  typedef struct packed {
    logic                 evict;
    logic [REG_IDX_W-1:0] idx;
    logic [ID_W-1:0]      victim_id;
  } pick_t;

  // spill slot bookkeeping for one interval
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  frame;
    logic              overflow;
  } spill_t;

endpackage

`default_nettype wire

/* rtl/core/lsra_pick.sv */
// ----------------------------------------------------------------------------
// lsra_pick
// Expires stale registers, finds the lowest free one, or else the eviction
// victim (largest end, then smallest owner id, then lowest register).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsra_pick (
  input  wire logic                          restart_i,
  input  wire logic [lsra_pkg::POS_W-1:0]    start_i,
  input  wire logic [lsra_pkg::NUM_REGS-1:0] busy_i,
  input  wire logic [lsra_pkg::POS_W-1:0]    reg_end_i   [lsra_pkg::NUM_REGS],
  input  wire logic [lsra_pkg::ID_W-1:0]     reg_owner_i [lsra_pkg::NUM_REGS],
  output logic      [lsra_pkg::NUM_REGS-1:0] live_o,
  output lsra_pkg::pick_t                    pick_o
);
  import lsra_pkg::*;

  logic                    free_found;
  logic [REG_IDX_W-1:0]    free_idx;
  logic [POS_W+ID_W-1:0]   best_key;
  logic [POS_W+ID_W-1:0]   cand_key;
  logic [REG_IDX_W-1:0]    best_idx;

  always_comb begin
    for (int r = 0; r < NUM_REGS; r++) begin
      live_o[r] = busy_i[r] & ~restart_i & ~(reg_end_i[r] < start_i);
    end
  end

  // lowest free register: scan down so the lowest one is kept
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int r = NUM_REGS - 1; r >= 0; r--) begin
      if (!live_o[r]) begin
        free_found = 1'b1;
        free_idx   = REG_IDX_W'(r);
      end
    end
  end

  // victim key: larger end wins, then smaller owner; strict compare keeps lowest reg
  always_comb begin
    best_key = {reg_end_i[0], ~reg_owner_i[0]};
    best_idx = '0;
    cand_key = best_key;
    for (int r = 1; r < NUM_REGS; r++) begin
      cand_key = {reg_end_i[r], ~reg_owner_i[r]};
      if (cand_key > best_key) begin
        best_key = cand_key;
        best_idx = REG_IDX_W'(r);
      end
    end
  end

  always_comb begin
    pick_o.evict     = ~free_found;
    pick_o.idx       = free_found ? free_idx : best_idx;
    pick_o.victim_id = free_found ? '0 : reg_owner_i[best_idx];
  end

endmodule

`default_nettype wire

/* rtl/core/lsra_spill.sv */
// ----------------------------------------------------------------------------
// lsra_spill
// Spill offset register: slot for an evicted interval, saturating advance,
// and the frame size rounded up to sixteen bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsra_spill (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic                       restart_i,
  input  wire logic                       evict_i,
  input  wire logic [lsra_pkg::OFF_W-1:0] base_i,
  output lsra_pkg::spill_t                spill_o
);
  import lsra_pkg::*;

  logic [OFF_W-1:0] offset_q, offset_d;
  logic [OFF_W-1:0] base_clamped;
  logic [OFF_W-1:0] off_cur;
  logic [OFF_W:0]   slot_mag;
  logic [OFF_W:0]   step_sum;
  logic             step_ovf;
  logic [OFF_W:0]   frame_sum;

  always_comb begin
    base_clamped = ({1'b0, base_i} > MAX_OFFSET) ? MAX_OFFSET[OFF_W-1:0] : base_i;
    off_cur      = restart_i ? base_clamped : offset_q;
    slot_mag     = {1'b0, off_cur} + SLOT_BIAS;
    step_sum     = ({1'b0, off_cur} + STEP_ROUND) & ALIGN4_MASK;
    step_ovf     = step_sum > MAX_OFFSET;
    if (evict_i) begin
      offset_d = step_ovf ? MAX_OFFSET[OFF_W-1:0] : step_sum[OFF_W-1:0];
    end else begin
      offset_d = off_cur;
    end
    frame_sum        = {1'b0, offset_d} + FRAME_ROUND;
    spill_o.slot     = evict_i ? ({SLOT_W{1'b0}} - slot_mag) : '0;
    spill_o.frame    = frame_sum[OFF_W-1:0] & ~FRAME_ROUND[OFF_W-1:0];
    spill_o.overflow = evict_i & step_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (adv_i) begin
      offset_q <= offset_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/linear_scan_register_assigner.sv */
// ----------------------------------------------------------------------------
// linear_scan_register_assigner
// Assigns registers to live intervals in start order, evicting to stack slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one live interval per
//   transaction; output channel (out_valid_o / out_stall_i) returns exactly
//   one result per interval, in order.
//   An accepted interval passes through the input register, then the result
//   register. Throughput: one interval per clock while the output is not stalled;
//   the expire/free/victim search over all registers plus the spill offset update
//   sit between the two, and the register state is written as the result loads.
//   A stalled receiver holds the result register; the input register keeps
//   filling, and in_stall_o rises only while both stages are full and the
//   output is stalled.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the spill base offset;
//   write it only while no interval is in flight. It takes effect at the next
//   interval with restart set.
//   Reset frees every register, clears the spill offset and the base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_scan_register_assigner (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // interval input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              restart_i,
  input  wire logic [lsra_pkg::ID_W-1:0]         interval_id_i,
  input  wire logic [lsra_pkg::POS_W-1:0]        interval_start_i,
  input  wire logic [lsra_pkg::POS_W-1:0]        interval_end_i,
  input  wire logic                              pre_spilled_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [lsra_pkg::OUTCOME_W-1:0]         outcome_o,
  output logic [lsra_pkg::REG_FIELD_W-1:0]       reg_index_o,
  output logic [lsra_pkg::ID_W-1:0]              victim_id_o,
  output logic signed [lsra_pkg::SLOT_W-1:0]     victim_slot_o,
  output logic [lsra_pkg::OFF_W-1:0]             frame_bytes_o,
  output logic                                   spill_overflow_o,
  // configuration
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lsra_pkg::OFF_W-1:0]        cfg_spill_base_offset_i
);
  import lsra_pkg::*;

  // input stage
  logic             s1_valid_q;
  logic             s1_restart_q;
  logic [ID_W-1:0]  s1_id_q;
  logic [POS_W-1:0] s1_start_q;
  logic [POS_W-1:0] s1_end_q;
  logic             s1_skip_q;
  logic             s1_adv;
  logic             in_accept;

  // register state
  logic [NUM_REGS-1:0] busy_q, busy_d;
  logic [POS_W-1:0]    reg_end_q   [NUM_REGS];
  logic [ID_W-1:0]     reg_owner_q [NUM_REGS];
  logic [NUM_REGS-1:0] live;

  logic [OFF_W-1:0] base_q;

  pick_t  pick;
  spill_t spill;
  logic   evict;

  // result register
  logic                   out_valid_q;
  outcome_e               outcome_q, outcome_d;
  logic [REG_FIELD_W-1:0] reg_index_q;
  logic [ID_W-1:0]        victim_id_q;
  logic [SLOT_W-1:0]      victim_slot_q;
  logic [OFF_W-1:0]       frame_q;
  logic                   overflow_q;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_restart_q <= restart_i;
      s1_id_q      <= interval_id_i;
      s1_start_q   <= interval_start_i;
      s1_end_q     <= interval_end_i;
      s1_skip_q    <= pre_spilled_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_spill_base_offset_i;
    end
  end

  lsra_pick u_pick (
    .restart_i   (s1_restart_q),
    .start_i     (s1_start_q),
    .busy_i      (busy_q),
    .reg_end_i   (reg_end_q),
    .reg_owner_i (reg_owner_q),
    .live_o      (live),
    .pick_o      (pick)
  );

  assign evict = pick.evict & ~s1_skip_q;

  lsra_spill u_spill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .restart_i (s1_restart_q),
    .evict_i   (evict),
    .base_i    (base_q),
    .spill_o   (spill)
  );

  always_comb begin
    if (s1_skip_q) begin
      busy_d = s1_restart_q ? '0 : busy_q;
    end else begin
      busy_d = live;
      busy_d[pick.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (s1_adv) begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_skip_q) begin
      reg_end_q[pick.idx]   <= s1_end_q;
      reg_owner_q[pick.idx] <= s1_id_q;
    end
  end

  always_comb begin
    if (s1_skip_q) begin
      outcome_d = OUT_SKIP;
    end else if (pick.evict) begin
      outcome_d = OUT_EVICT;
    end else begin
      outcome_d = OUT_GRANT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      outcome_q     <= outcome_d;
      reg_index_q   <= s1_skip_q ? '0 : REG_FIELD_W'(pick.idx);
      victim_id_q   <= evict ? pick.victim_id : '0;
      victim_slot_q <= spill.slot;
      frame_q       <= spill.frame;
      overflow_q    <= spill.overflow;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign reg_index_o      = reg_index_q;
  assign victim_id_o      = victim_id_q;
  assign victim_slot_o    = victim_slot_q;
  assign frame_bytes_o    = frame_q;
  assign spill_overflow_o = overflow_q;

endmodule

`default_nettype wire

/* rtl/core/lsra_checker.sv */
// ----------------------------------------------------------------------------
// lsra_checker
// Port-level checks on the register assigner's results, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsra_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic [lsra_pkg::OUTCOME_W-1:0]     outcome_o,
  input wire logic [lsra_pkg::REG_FIELD_W-1:0]   reg_index_o,
  input wire logic [lsra_pkg::ID_W-1:0]          victim_id_o,
  input wire logic signed [lsra_pkg::SLOT_W-1:0] victim_slot_o,
  input wire logic                               spill_overflow_o
);
  import lsra_pkg::*;

  // skipped intervals carry no register and no victim
  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUT_SKIP) |->
      (reg_index_o == '0 && victim_id_o == '0 && victim_slot_o == '0
       && !spill_overflow_o))
    else $error("skip result carries register or spill data");

  // a free grant never spills
  a_grant_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUT_GRANT) |->
      (victim_id_o == '0 && victim_slot_o == '0 && !spill_overflow_o))
    else $error("grant result carries spill data");

  // an eviction always gets a negative frame slot
  a_evict_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUT_EVICT) |-> (victim_slot_o < 0))
    else $error("eviction without a negative slot");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (outcome_o == OUT_GRANT || outcome_o == OUT_EVICT || outcome_o == OUT_SKIP))
    else $error("unknown outcome code");

  // a stalled result transaction stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

bind linear_scan_register_assigner lsra_checker u_lsra_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .outcome_o        (outcome_o),
  .reg_index_o      (reg_index_o),
  .victim_id_o      (victim_id_o),
  .victim_slot_o    (victim_slot_o),
  .spill_overflow_o (spill_overflow_o)
);

`default_nettype wire

/* tb/linear_scan_register_assigner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_register_assigner_tb
// Self-checking bench for the linear-scan register assigner. Live intervals go
// in from a queue with random gaps. A local copy of the register file and
// spill offset predicts each result. Results are taken under random stall and
// compared field by field in order. The spill base is rewritten between
// phases, from zero up to values past the offset limit.
// ----------------------------------------------------------------------------

module linear_scan_register_assigner_tb;
  import lsra_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic             restart;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic             pre_spilled;
    int unsigned      gap;
    logic             drain_first;  // hold until all results are back
    logic             calm;         // no receiver stall while this is in flight
  } interval_t;

  typedef struct {
    outcome_e                 outcome;
    logic [REG_FIELD_W-1:0]   reg_index;
    logic [ID_W-1:0]          victim_id;
    logic signed [SLOT_W-1:0] victim_slot;
    logic [OFF_W-1:0]         frame_bytes;
    logic                     spill_overflow;
  } assignment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     restart = 1'b0;
  logic [ID_W-1:0]          interval_id = '0;
  logic [POS_W-1:0]         interval_start = '0;
  logic [POS_W-1:0]         interval_last = '0;
  logic                     pre_spilled = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [OUTCOME_W-1:0]     outcome;
  logic [REG_FIELD_W-1:0]   reg_index;
  logic [ID_W-1:0]          victim_id;
  logic signed [SLOT_W-1:0] victim_slot;
  logic [OFF_W-1:0]         frame_bytes;
  logic                     spill_overflow;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [OFF_W-1:0]         cfg_base = '0;

  interval_t   pending_intervals[$];
  assignment_t expected_assignments[$];
  interval_t   in_flight;
  logic        slot_full = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cycles = 0;
  logic        rx_calm = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // predicted register file and spill state
  logic             live_busy [NUM_REGS];
  logic [POS_W-1:0] live_end [NUM_REGS];
  logic [ID_W-1:0]  live_owner [NUM_REGS];
  int unsigned      spill_off = 0;
  logic [OFF_W-1:0] spill_base = '0;

  linear_scan_register_assigner uut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .restart_i               (restart),
    .interval_id_i           (interval_id),
    .interval_start_i        (interval_start),
    .interval_end_i          (interval_last),
    .pre_spilled_i           (pre_spilled),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .outcome_o               (outcome),
    .reg_index_o             (reg_index),
    .victim_id_o             (victim_id),
    .victim_slot_o           (victim_slot),
    .frame_bytes_o           (frame_bytes),
    .spill_overflow_o        (spill_overflow),
    .cfg_valid_i             (cfg_valid),
    .cfg_ready_o             (cfg_ready),
    .cfg_spill_base_offset_i (cfg_base)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned draw_wait(logic calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  function automatic assignment_t assign_register(interval_t iv);
    assignment_t a;
    int          pick;
    int unsigned nxt;
    a.outcome        = OUT_GRANT;
    a.reg_index      = '0;
    a.victim_id      = '0;
    a.victim_slot    = '0;
    a.spill_overflow = 1'b0;
    pick             = -1;
    if (iv.restart) begin
      for (int r = 0; r < NUM_REGS; r++) live_busy[r] = 1'b0;
      spill_off = (spill_base > MAX_OFFSET) ? int'(MAX_OFFSET) : int'(spill_base);
    end
    if (iv.pre_spilled) begin
      a.outcome = OUT_SKIP;
    end else begin
      for (int r = 0; r < NUM_REGS; r++)
        if (live_busy[r] && live_end[r] < iv.first_pos) live_busy[r] = 1'b0;
      for (int r = 0; r < NUM_REGS; r++)
        if (pick < 0 && !live_busy[r]) pick = r;
      if (pick < 0) begin
        // all busy: furthest end goes, then smallest owner, then lowest register
        pick = 0;
        for (int r = 1; r < NUM_REGS; r++)
          if (live_end[r] > live_end[pick] ||
              (live_end[r] == live_end[pick] && live_owner[r] < live_owner[pick]))
            pick = r;
        a.outcome     = OUT_EVICT;
        a.victim_id   = live_owner[pick];
        a.victim_slot = SLOT_W'(-(int'(SLOT_BIAS) + int'(spill_off)));
        nxt = (spill_off + SLOT_STEP + 3) & ~32'd3;
        if (nxt > MAX_OFFSET) begin
          nxt              = MAX_OFFSET;
          a.spill_overflow = 1'b1;
        end
        spill_off = nxt;
      end
      live_busy[pick]  = 1'b1;
      live_end[pick]   = iv.last_pos;
      live_owner[pick] = iv.id;
      a.reg_index      = REG_FIELD_W'(pick);
    end
    a.frame_bytes = OFF_W'((spill_off + FRAME_ROUND) & ~32'd15);
    return a;
  endfunction

  // sender: one interval per transaction, gap drawn per item
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_assignments = {expected_assignments, assign_register(in_flight)};
        slot_full = 1'b0;
      end
      if (!slot_full && pending_intervals.size() != 0) begin
        if (idle_cycles < pending_intervals[0].gap) begin
          idle_cycles++;
        end else if (!pending_intervals[0].drain_first ||
                     expected_assignments.size() == 0) begin
          in_flight      = pending_intervals.pop_front();
          slot_full      = 1'b1;
          idle_cycles    = 0;
          rx_calm        = in_flight.calm;
          restart        <= in_flight.restart;
          interval_id    <= in_flight.id;
          interval_start <= in_flight.first_pos;
          interval_last  <= in_flight.last_pos;
          pre_spilled    <= in_flight.pre_spilled;
        end
      end
      in_valid <= slot_full;
    end
  end

  // receiver: check each result against the oldest prediction
  always @(posedge clk) begin
    assignment_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_assignments.size() == 0) begin
          $error("result with no interval outstanding");
          errors++;
        end else begin
          want = expected_assignments.pop_front();
          if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome);
            errors++;
          end
          if (reg_index !== want.reg_index) begin
            $error("reg_index: expected %0d, got %0d", want.reg_index, reg_index);
            errors++;
          end
          if (victim_id !== want.victim_id) begin
            $error("victim_id: expected %0d, got %0d", want.victim_id, victim_id);
            errors++;
          end
          if (victim_slot !== want.victim_slot) begin
            $error("victim_slot: expected %0d, got %0d", want.victim_slot, victim_slot);
            errors++;
          end
          if (frame_bytes !== want.frame_bytes) begin
            $error("frame_bytes: expected %0d, got %0d", want.frame_bytes, frame_bytes);
            errors++;
          end
          if (spill_overflow !== want.spill_overflow) begin
            $error("spill_overflow: expected %0d, got %0d", want.spill_overflow,
                   spill_overflow);
            errors++;
          end
        end
        hold_cycles = draw_wait(rx_calm);
      end
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_interval(input logic rs, input logic [ID_W-1:0] id,
                               input logic [POS_W-1:0] first_pos,
                               input logic [POS_W-1:0] last_pos, input logic pre,
                               input logic drain, input logic calm);
    interval_t iv;
    iv.restart     = rs;
    iv.id          = id;
    iv.first_pos   = first_pos;
    iv.last_pos    = last_pos;
    iv.pre_spilled = pre;
    iv.drain_first = drain;
    iv.calm        = calm;
    iv.gap         = draw_wait(calm);
    pending_intervals = {pending_intervals, iv};
  endtask

  task automatic write_spill_base(input logic [OFF_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_base  <= value;
    do @(posedge clk); while (!cfg_ready);
    spill_base = value;
    cfg_valid  <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_intervals.size() != 0 || slot_full || expected_assignments.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // well-formed runs (restart, rising starts and ids) mixed with raw noise
  task automatic fill_random(input int unsigned count);
    int unsigned added;
    int unsigned run_len;
    int unsigned span;
    int unsigned pos;
    int unsigned next_id;
    logic        calm;
    added = 0;
    while (added < count) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        push_interval($urandom_range(0, 9) == 0, ID_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, calm);
        added++;
      end else begin
        run_len = $urandom_range(10, 40);
        pos     = $urandom_range(0, 65000);
        next_id = $urandom_range(0, 4095);
        for (int k = 0; k < run_len && added < count; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: span = $urandom_range(0, 15);
            5, 6, 7, 8:    span = $urandom_range(16, 400);
            default:       span = 65535;
          endcase
          push_interval(k == 0, ID_W'(next_id), POS_W'(pos),
                        POS_W'((pos + span > 65535) ? 65535 : pos + span),
                        $urandom_range(0, 9) == 0,
                        k == 0 && $urandom_range(0, 7) == 0, calm);
          pos     = pos + $urandom_range(0, 6);
          pos     = (pos > 65535) ? 65535 : pos;
          next_id = next_id + $urandom_range(1, 2);
          added++;
        end
      end
    end
  endtask

  initial begin
    logic [POS_W-1:0] fill_end [8];
    logic [OFF_W-1:0] phase_base [6];
    for (int r = 0; r < NUM_REGS; r++) begin
      live_busy[r]  = 1'b0;
      live_end[r]   = '0;
      live_owner[r] = '0;
    end
    fill_end   = '{16'd7, 16'd65535, 16'd7, 16'd300, 16'd65535, 16'd0, 16'd300, 16'd4095};
    phase_base = '{16'd6, 16'd0, 16'd32760, 16'd0, 16'd32768, 16'd0};
    phase_base[3] = OFF_W'($urandom_range(0, 8192) * 4);
    phase_base[5] = OFF_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // base above the limit: loads as the maximum, so evictions saturate
    write_spill_base(16'hFFFF);
    push_interval(1'b1, 12'd0, 16'd0, 16'd65535, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++)
      push_interval(1'b0, ID_W'(i + 1), 16'd0, fill_end[i], 1'b0, 1'b0, 1'b0);
    // full: tie on the far end goes to the smallest owner
    push_interval(1'b0, 12'd9, 16'd0, 16'd65535, 1'b0, 1'b0, 1'b0);
    // repeated id, evicts again at the clamped slot
    push_interval(1'b0, 12'd2, 16'd0, 16'd100, 1'b0, 1'b0, 1'b0);
    push_interval(1'b0, 12'd10, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0);
    // restart still applies on a pre-spilled item
    push_interval(1'b1, 12'd11, 16'd1, 16'd1, 1'b1, 1'b0, 1'b0);
    push_interval(1'b0, 12'd4095, 16'd65535, 16'd65535, 1'b0, 1'b0, 1'b1);
    push_interval(1'b0, 12'd12, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    wait_idle();

    foreach (phase_base[p]) begin
      write_spill_base(phase_base[p]);
      fill_random(75);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lsra_pkg.sv
rtl/core/lsra_pick.sv
rtl/core/lsra_spill.sv
rtl/core/linear_scan_register_assigner.sv
rtl/core/lsra_checker.sv
tb/linear_scan_register_assigner_tb.sv
